@@ hw/rtl/sfcs_pkg.sv @@
// ----------------------------------------------------------------------------
// sfcs_pkg: shared types and constants of the SPI flash command sequencer
// Item and result structs, command and phase codes, 25-series opcodes.
// ----------------------------------------------------------------------------
package sfcs_pkg;

  localparam int AddrBits    = 24;
  localparam int LenBits     = 16;
  localparam int MaxResults  = 3;
  localparam int ResIdxBits  = 2;
  localparam int FifoDepth   = 8;
  localparam int FifoPtrBits = 3;
  localparam int FifoCntBits = 4;

  typedef enum logic [1:0] {
    InRequest = 2'd0,
    InPayload = 2'd1,
    InReturn  = 2'd2,
    InNone    = 2'd3
  } in_op_e;

  typedef enum logic [3:0] {
    CmdRdsr       = 4'd0,
    CmdWren       = 4'd1,
    CmdWrdi       = 4'd2,
    CmdWrsr       = 4'd3,
    CmdProgram    = 4'd4,
    CmdFastRead   = 4'd5,
    CmdSectorEr   = 4'd6,
    CmdBlockEr    = 4'd7,
    CmdChipErase  = 4'd8
  } command_e;

  typedef enum logic [1:0] {
    ActSend    = 2'd0,
    ActRelease = 2'd1,
    ActData    = 2'd2,
    ActDone    = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    PhIdle        = 5'd0,
    PhWeCmd       = 5'd1,
    PhWeOp        = 5'd2,
    PhWeData      = 5'd3,
    PhRdOp        = 5'd4,
    PhRdData      = 5'd5,
    PhCmd         = 5'd6,
    PhAddr        = 5'd7,
    PhDummy       = 5'd8,
    PhWrsrVal     = 5'd9,
    PhPayloadWait = 5'd10,
    PhPayloadRet  = 5'd11,
    PhReadRet     = 5'd12,
    PhBusyOp      = 5'd13,
    PhBusyData    = 5'd14
  } phase_e;

  localparam logic [7:0] FlashRdsr     = 8'h05;
  localparam logic [7:0] FlashWren     = 8'h06;
  localparam logic [7:0] FlashWrdi     = 8'h04;
  localparam logic [7:0] FlashWrsr     = 8'h01;
  localparam logic [7:0] FlashProgram  = 8'h02;
  localparam logic [7:0] FlashFastRead = 8'h0B;
  localparam logic [7:0] FlashSectorEr = 8'h20;
  localparam logic [7:0] FlashBlockEr  = 8'h52;
  localparam logic [7:0] FlashChipEr   = 8'h60;
  localparam logic [7:0] FlashDummy    = 8'hFF;

  typedef struct packed {
    in_op_e                opcode;
    logic [3:0]            command;
    logic [AddrBits-1:0]   flash_address;
    logic [LenBits-1:0]    byte_count;
    logic [7:0]            value;
  } in_item_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] tx_byte;
    logic [7:0] data_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [ResIdxBits-1:0]       count;
    result_t [MaxResults-1:0]    res;
  } push_t;

  function automatic result_t mk_result(action_e act, logic [7:0] tx, logic [7:0] data);
    result_t r;
    r.action    = act;
    r.tx_byte   = tx;
    r.data_byte = data;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] main_opcode(logic [3:0] cmd);
    logic [7:0] op;
    case (cmd)
      CmdWrsr:     op = FlashWrsr;
      CmdProgram:  op = FlashProgram;
      CmdFastRead: op = FlashFastRead;
      CmdSectorEr: op = FlashSectorEr;
      CmdBlockEr:  op = FlashBlockEr;
      default:     op = FlashChipEr;
    endcase
    return op;
  endfunction

  // address goes out high byte first
  function automatic logic [7:0] addr_byte(logic [AddrBits-1:0] addr, logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = addr[23:16];
      2'd1:    b = addr[15:8];
      default: b = addr[7:0];
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/spi_flash_command_sequencer.sv @@
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer: 25-series SPI NOR flash command sequencer
// Builds command frames, address bytes and status polls as byte results.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: requests, program payload bytes and the byte each SPI
//   transfer returns, as in_item_t. Every send result must be answered by
//   one return item before the frame moves on; items out of turn are dropped.
//   out channel: result_t per transfer (send byte, release select, data,
//   done); last marks the final result caused by one input item.
// Timing: an accepted item is held in the input register until the result
//   queue has room; then the core steps it combinationally and its results
//   are written into the queue, whose registered head offers the first one.
// Throughput: one item per cycle while each item yields one result and the
//   receiver takes one per cycle. An item yields up to three results; the
//   eight-entry result queue pulls in the next item only while three entries
//   are free, so the output port, one result a cycle, sets the rate.
// Reset: the frame state returns to idle and the queue empties.
// Stall: a stalled receiver fills the queue; the input register then holds
//   its item and in_ready_o drops until room opens up.
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sfcs_pkg::in_item_t in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sfcs_pkg::result_t  out_o
);

  sfcs_pkg::in_item_t item_q;
  logic               item_valid_q, item_valid_d;
  logic               space_ok;
  logic               go;
  logic               in_fire;
  sfcs_pkg::push_t    push;

  assign go           = item_valid_q && space_ok;
  assign in_ready_o   = !item_valid_q || go;
  assign in_fire      = in_valid_i && in_ready_o;
  assign item_valid_d = in_fire || (item_valid_q && !go);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  sfcs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .item_i (item_q),
    .push_o (push)
  );

  sfcs_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

@@ hw/rtl/sfcs_core.sv @@
// ----------------------------------------------------------------------------
// sfcs_core: command sequencing state and per-transfer step logic
// Holds the frame state and turns one item into up to three results.
// ----------------------------------------------------------------------------
module sfcs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  sfcs_pkg::in_item_t item_i,
  output sfcs_pkg::push_t   push_o
);

  sfcs_pkg::phase_e              phase_q, phase_d;
  logic [3:0]                    cmd_q, cmd_d;
  logic [sfcs_pkg::AddrBits-1:0] addr_q, addr_d;
  logic [sfcs_pkg::LenBits-1:0]  left_q, left_d;
  logic [1:0]                    idx_q, idx_d;
  logic [7:0]                    status_q, status_d;

  sfcs_pkg::result_t [sfcs_pkg::MaxResults-1:0] res;
  logic [sfcs_pkg::ResIdxBits-1:0]              n;
  logic [sfcs_pkg::LenBits-1:0]                 left_dec;
  logic                                         want_wel;

  assign left_dec = left_q - sfcs_pkg::LenBits'(1);
  assign want_wel = (cmd_q != sfcs_pkg::CmdWrdi);

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    addr_d   = addr_q;
    left_d   = left_q;
    idx_d    = idx_q;
    status_d = status_q;
    n        = '0;
    for (int i = 0; i < sfcs_pkg::MaxResults; i++) begin
      res[i] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, 8'h00, 8'h00);
    end

    if (go_i) begin
      case (item_i.opcode)
        sfcs_pkg::InRequest: begin
          if (phase_q == sfcs_pkg::PhIdle && item_i.command <= sfcs_pkg::CmdChipErase) begin
            cmd_d    = item_i.command;
            addr_d   = item_i.flash_address;
            left_d   = item_i.byte_count;
            status_d = item_i.value;
            idx_d    = 2'd0;
            if (item_i.command == sfcs_pkg::CmdRdsr) begin
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
              n = n + 2'd1;
              phase_d = sfcs_pkg::PhRdOp;
            end else if (item_i.command == sfcs_pkg::CmdFastRead) begin
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend,
                                           sfcs_pkg::main_opcode(item_i.command), 8'h00);
              n = n + 2'd1;
              phase_d = sfcs_pkg::PhCmd;
            end else begin
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend,
                (item_i.command == sfcs_pkg::CmdWrdi) ? sfcs_pkg::FlashWrdi
                                                      : sfcs_pkg::FlashWren, 8'h00);
              n = n + 2'd1;
              phase_d = sfcs_pkg::PhWeCmd;
            end
          end
        end
        sfcs_pkg::InPayload: begin
          if (phase_q == sfcs_pkg::PhPayloadWait) begin
            res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, item_i.value, 8'h00);
            n = n + 2'd1;
            phase_d = sfcs_pkg::PhPayloadRet;
          end
        end
        sfcs_pkg::InReturn: begin
          case (phase_q)
            sfcs_pkg::PhWeCmd: begin
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActRelease, 8'h00, 8'h00);
              n = n + 2'd1;
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
              n = n + 2'd1;
              phase_d = sfcs_pkg::PhWeOp;
            end
            sfcs_pkg::PhWeOp: begin
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashDummy, 8'h00);
              n = n + 2'd1;
              phase_d = sfcs_pkg::PhWeData;
            end
            sfcs_pkg::PhWeData: begin
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActRelease, 8'h00, 8'h00);
              n = n + 2'd1;
              if (item_i.value[1] != want_wel) begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhWeOp;
              end else if (cmd_q == sfcs_pkg::CmdWren || cmd_q == sfcs_pkg::CmdWrdi) begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActDone, 8'h00, 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhIdle;
              end else begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend,
                                             sfcs_pkg::main_opcode(cmd_q), 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhCmd;
              end
            end
            sfcs_pkg::PhRdOp: begin
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashDummy, 8'h00);
              n = n + 2'd1;
              phase_d = sfcs_pkg::PhRdData;
            end
            sfcs_pkg::PhRdData: begin
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActRelease, 8'h00, 8'h00);
              n = n + 2'd1;
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActData, 8'h00, item_i.value);
              n = n + 2'd1;
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActDone, 8'h00, 8'h00);
              n = n + 2'd1;
              phase_d = sfcs_pkg::PhIdle;
            end
            sfcs_pkg::PhCmd: begin
              if (cmd_q == sfcs_pkg::CmdWrsr) begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, status_q, 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhWrsrVal;
              end else if (cmd_q == sfcs_pkg::CmdChipErase) begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActRelease, 8'h00, 8'h00);
                n = n + 2'd1;
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhBusyOp;
              end else begin
                idx_d  = 2'd0;
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend,
                                             sfcs_pkg::addr_byte(addr_q, 2'd0), 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhAddr;
              end
            end
            sfcs_pkg::PhAddr: begin
              if (idx_q < 2'd2) begin
                idx_d  = idx_q + 2'd1;
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend,
                                             sfcs_pkg::addr_byte(addr_q, idx_q + 2'd1), 8'h00);
                n = n + 2'd1;
              end else if (cmd_q == sfcs_pkg::CmdProgram && left_q != '0) begin
                phase_d = sfcs_pkg::PhPayloadWait;
              end else if (cmd_q == sfcs_pkg::CmdFastRead) begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashDummy, 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhDummy;
              end else begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActRelease, 8'h00, 8'h00);
                n = n + 2'd1;
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhBusyOp;
              end
            end
            sfcs_pkg::PhDummy: begin
              if (left_q == '0) begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActRelease, 8'h00, 8'h00);
                n = n + 2'd1;
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhBusyOp;
              end else begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashDummy, 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhReadRet;
              end
            end
            sfcs_pkg::PhReadRet: begin
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActData, 8'h00, item_i.value);
              n = n + 2'd1;
              left_d = left_dec;
              if (left_dec == '0) begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActRelease, 8'h00, 8'h00);
                n = n + 2'd1;
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhBusyOp;
              end else begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashDummy, 8'h00);
                n = n + 2'd1;
              end
            end
            sfcs_pkg::PhWrsrVal: begin
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActRelease, 8'h00, 8'h00);
              n = n + 2'd1;
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
              n = n + 2'd1;
              phase_d = sfcs_pkg::PhBusyOp;
            end
            sfcs_pkg::PhPayloadRet: begin
              left_d = left_dec;
              if (left_dec == '0) begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActRelease, 8'h00, 8'h00);
                n = n + 2'd1;
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhBusyOp;
              end else begin
                phase_d = sfcs_pkg::PhPayloadWait;
              end
            end
            sfcs_pkg::PhBusyOp: begin
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashDummy, 8'h00);
              n = n + 2'd1;
              phase_d = sfcs_pkg::PhBusyData;
            end
            sfcs_pkg::PhBusyData: begin
              res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActRelease, 8'h00, 8'h00);
              n = n + 2'd1;
              if (item_i.value[0]) begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhBusyOp;
              end else begin
                res[n] = sfcs_pkg::mk_result(sfcs_pkg::ActDone, 8'h00, 8'h00);
                n = n + 2'd1;
                phase_d = sfcs_pkg::PhIdle;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    if (n != '0) begin
      res[n - 2'd1].last = 1'b1;
    end
  end

  assign push_o.count = n;
  assign push_o.res   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sfcs_pkg::PhIdle;
      cmd_q    <= '0;
      addr_q   <= '0;
      left_q   <= '0;
      idx_q    <= '0;
      status_q <= '0;
    end else begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      addr_q   <= addr_d;
      left_q   <= left_d;
      idx_q    <= idx_d;
      status_q <= status_d;
    end
  end

endmodule

@@ hw/rtl/sfcs_out_fifo.sv @@
// ----------------------------------------------------------------------------
// sfcs_out_fifo: result queue
// Takes up to three results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module sfcs_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfcs_pkg::push_t    push_i,
  output logic               space_ok_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sfcs_pkg::result_t  out_o
);

  sfcs_pkg::result_t                mem_q [sfcs_pkg::FifoDepth];
  logic [sfcs_pkg::FifoPtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [sfcs_pkg::FifoPtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [sfcs_pkg::FifoCntBits-1:0] cnt_q, cnt_d;
  logic                             pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign space_ok_o  = (cnt_q <= sfcs_pkg::FifoCntBits'(sfcs_pkg::FifoDepth -
                                                         sfcs_pkg::MaxResults));

  assign wr_ptr_d = wr_ptr_q + sfcs_pkg::FifoPtrBits'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + sfcs_pkg::FifoPtrBits'(pop);
  assign cnt_d    = cnt_q + sfcs_pkg::FifoCntBits'(push_i.count)
                          - sfcs_pkg::FifoCntBits'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < sfcs_pkg::MaxResults; i++) begin
      if (sfcs_pkg::ResIdxBits'(i) < push_i.count) begin
        mem_q[wr_ptr_q + sfcs_pkg::FifoPtrBits'(i)] <= push_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/sfcs_checker.sv @@
// ----------------------------------------------------------------------------
// sfcs_checker: port-level checks for the SPI flash command sequencer
// Watches the top-level channels; attached by bind.
// ----------------------------------------------------------------------------
module sfcs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input sfcs_pkg::in_item_t in_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sfcs_pkg::result_t  out_o
);

  // an offered item holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_i))
    else $error("input item changed while stalled");

  // a waiting result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  // input backpressure only comes from pending results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // done always closes the results of one item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.action == sfcs_pkg::ActDone |-> out_o.last)
    else $error("done without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.action == sfcs_pkg::ActData || out_o.data_byte == 8'h00) &&
                    (out_o.action == sfcs_pkg::ActSend || out_o.tx_byte == 8'h00))
    else $error("unused result byte not zero");

endmodule

bind spi_flash_command_sequencer sfcs_checker u_sfcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

@@ tb/spi_flash_command_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer_tb: self-checking bench for the flash sequencer
// Plays the SPI side and the requester in closed loop, predicts every frame
// byte, release, data and done, and checks the result stream in order.
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer_tb;

  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 12;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  sfcs_pkg::in_item_t in_i        = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  sfcs_pkg::result_t  out_o;

  spi_flash_command_sequencer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // sequencer state as the bench sees it
  sfcs_pkg::phase_e fl_phase;
  logic [3:0]       fl_cmd;
  logic [23:0]      fl_addr;
  logic [15:0]      fl_left;
  logic [1:0]       fl_idx;
  logic [7:0]       fl_status;

  sfcs_pkg::result_t step_res[$];
  sfcs_pkg::result_t expected_results[$];

  int mismatches = 0;
  int work_items = 0;
  int noise_pct  = 0;
  int burst_left = 0;

  function automatic void put(sfcs_pkg::action_e act, logic [7:0] tx, logic [7:0] data);
    sfcs_pkg::result_t r;
    r.action    = act;
    r.tx_byte   = tx;
    r.data_byte = data;
    r.last      = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void begin_busy_poll();
    put(sfcs_pkg::ActRelease, 8'h00, 8'h00);
    put(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
    fl_phase = sfcs_pkg::PhBusyOp;
  endfunction

  function automatic void begin_frame();
    logic [7:0] op;
    case (fl_cmd)
      sfcs_pkg::CmdWrsr:     op = sfcs_pkg::FlashWrsr;
      sfcs_pkg::CmdProgram:  op = sfcs_pkg::FlashProgram;
      sfcs_pkg::CmdFastRead: op = sfcs_pkg::FlashFastRead;
      sfcs_pkg::CmdSectorEr: op = sfcs_pkg::FlashSectorEr;
      sfcs_pkg::CmdBlockEr:  op = sfcs_pkg::FlashBlockEr;
      default:               op = sfcs_pkg::FlashChipEr;
    endcase
    put(sfcs_pkg::ActSend, op, 8'h00);
    fl_phase = sfcs_pkg::PhCmd;
  endfunction

  function automatic void send_address_byte();
    logic [23:0] shifted;
    shifted = fl_addr >> (16 - 8 * int'(fl_idx));
    put(sfcs_pkg::ActSend, shifted[7:0], 8'h00);
  endfunction

  function automatic void take_request(sfcs_pkg::in_item_t it);
    if (fl_phase != sfcs_pkg::PhIdle || it.command > sfcs_pkg::CmdChipErase) return;
    fl_cmd    = it.command;
    fl_addr   = it.flash_address;
    fl_left   = it.byte_count;
    fl_status = it.value;
    fl_idx    = 2'd0;
    if (fl_cmd == sfcs_pkg::CmdRdsr) begin
      put(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
      fl_phase = sfcs_pkg::PhRdOp;
    end else if (fl_cmd == sfcs_pkg::CmdFastRead) begin
      begin_frame();
    end else begin
      put(sfcs_pkg::ActSend, (fl_cmd == sfcs_pkg::CmdWrdi) ? sfcs_pkg::FlashWrdi
                                                           : sfcs_pkg::FlashWren, 8'h00);
      fl_phase = sfcs_pkg::PhWeCmd;
    end
  endfunction

  function automatic void take_return(logic [7:0] v);
    case (fl_phase)
      sfcs_pkg::PhWeCmd: begin
        put(sfcs_pkg::ActRelease, 8'h00, 8'h00);
        put(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
        fl_phase = sfcs_pkg::PhWeOp;
      end
      sfcs_pkg::PhWeOp: begin
        put(sfcs_pkg::ActSend, sfcs_pkg::FlashDummy, 8'h00);
        fl_phase = sfcs_pkg::PhWeData;
      end
      sfcs_pkg::PhWeData: begin
        put(sfcs_pkg::ActRelease, 8'h00, 8'h00);
        if (v[1] != (fl_cmd != sfcs_pkg::CmdWrdi)) begin
          put(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
          fl_phase = sfcs_pkg::PhWeOp;
        end else if (fl_cmd == sfcs_pkg::CmdWren || fl_cmd == sfcs_pkg::CmdWrdi) begin
          put(sfcs_pkg::ActDone, 8'h00, 8'h00);
          fl_phase = sfcs_pkg::PhIdle;
        end else begin
          begin_frame();
        end
      end
      sfcs_pkg::PhRdOp: begin
        put(sfcs_pkg::ActSend, sfcs_pkg::FlashDummy, 8'h00);
        fl_phase = sfcs_pkg::PhRdData;
      end
      sfcs_pkg::PhRdData: begin
        put(sfcs_pkg::ActRelease, 8'h00, 8'h00);
        put(sfcs_pkg::ActData, 8'h00, v);
        put(sfcs_pkg::ActDone, 8'h00, 8'h00);
        fl_phase = sfcs_pkg::PhIdle;
      end
      sfcs_pkg::PhCmd: begin
        if (fl_cmd == sfcs_pkg::CmdWrsr) begin
          put(sfcs_pkg::ActSend, fl_status, 8'h00);
          fl_phase = sfcs_pkg::PhWrsrVal;
        end else if (fl_cmd == sfcs_pkg::CmdChipErase) begin
          begin_busy_poll();
        end else begin
          fl_idx = 2'd0;
          send_address_byte();
          fl_phase = sfcs_pkg::PhAddr;
        end
      end
      sfcs_pkg::PhAddr: begin
        if (fl_idx < 2'd2) begin
          fl_idx++;
          send_address_byte();
        end else if (fl_cmd == sfcs_pkg::CmdProgram) begin
          if (fl_left == 16'd0) begin_busy_poll();
          else fl_phase = sfcs_pkg::PhPayloadWait;
        end else if (fl_cmd == sfcs_pkg::CmdFastRead) begin
          put(sfcs_pkg::ActSend, sfcs_pkg::FlashDummy, 8'h00);
          fl_phase = sfcs_pkg::PhDummy;
        end else begin
          begin_busy_poll();
        end
      end
      sfcs_pkg::PhDummy: begin
        if (fl_left == 16'd0) begin
          begin_busy_poll();
        end else begin
          put(sfcs_pkg::ActSend, sfcs_pkg::FlashDummy, 8'h00);
          fl_phase = sfcs_pkg::PhReadRet;
        end
      end
      sfcs_pkg::PhReadRet: begin
        put(sfcs_pkg::ActData, 8'h00, v);
        fl_left--;
        if (fl_left == 16'd0) begin_busy_poll();
        else put(sfcs_pkg::ActSend, sfcs_pkg::FlashDummy, 8'h00);
      end
      sfcs_pkg::PhWrsrVal: begin
        begin_busy_poll();
      end
      sfcs_pkg::PhPayloadRet: begin
        fl_left--;
        if (fl_left == 16'd0) begin_busy_poll();
        else fl_phase = sfcs_pkg::PhPayloadWait;
      end
      sfcs_pkg::PhBusyOp: begin
        put(sfcs_pkg::ActSend, sfcs_pkg::FlashDummy, 8'h00);
        fl_phase = sfcs_pkg::PhBusyData;
      end
      sfcs_pkg::PhBusyData: begin
        put(sfcs_pkg::ActRelease, 8'h00, 8'h00);
        if (v[0]) begin
          put(sfcs_pkg::ActSend, sfcs_pkg::FlashRdsr, 8'h00);
          fl_phase = sfcs_pkg::PhBusyOp;
        end else begin
          put(sfcs_pkg::ActDone, 8'h00, 8'h00);
          fl_phase = sfcs_pkg::PhIdle;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_flash_step(sfcs_pkg::in_item_t it);
    step_res.delete();
    case (it.opcode)
      sfcs_pkg::InRequest: take_request(it);
      sfcs_pkg::InPayload: begin
        if (fl_phase == sfcs_pkg::PhPayloadWait) begin
          put(sfcs_pkg::ActSend, it.value, 8'h00);
          fl_phase = sfcs_pkg::PhPayloadRet;
        end
      end
      sfcs_pkg::InReturn: take_return(it.value);
      default: ;
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) expected_results.push_back(step_res[i]);
  endfunction

  function automatic sfcs_pkg::in_item_t make_item(sfcs_pkg::in_op_e op, logic [3:0] cmd,
                                                   logic [23:0] addr, logic [15:0] cnt,
                                                   logic [7:0] v);
    sfcs_pkg::in_item_t it;
    it.opcode        = op;
    it.command       = cmd;
    it.flash_address = addr;
    it.byte_count    = cnt;
    it.value         = v;
    return it;
  endfunction

  // one transfer on the input channel, with bursts and gaps
  task automatic drive_item(sfcs_pkg::in_item_t it);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_i       <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_flash_step(it);
  endtask

  // only called mid-frame, so every choice here is dropped by the block
  task automatic drive_noise();
    case ($urandom_range(2))
      0: drive_item(make_item(sfcs_pkg::InRequest, 4'($urandom), 24'($urandom),
                              16'($urandom), 8'($urandom)));
      1: drive_item(make_item(sfcs_pkg::InNone, 4'($urandom), 24'($urandom),
                              16'($urandom), 8'($urandom)));
      default: drive_item(make_item((fl_phase == sfcs_pkg::PhPayloadWait) ?
                                    sfcs_pkg::InReturn : sfcs_pkg::InPayload,
                                    4'($urandom), 24'($urandom), 16'($urandom),
                                    8'($urandom)));
    endcase
  endtask

  // act as SPI slave and payload source until the frame is done
  task automatic drive_to_idle(int we_fails, int busy_fails);
    logic [7:0]       v;
    sfcs_pkg::in_op_e op;
    while (fl_phase != sfcs_pkg::PhIdle) begin
      if ($urandom_range(99) < noise_pct) begin
        drive_noise();
      end else begin
        v  = 8'($urandom);
        op = sfcs_pkg::InReturn;
        case (fl_phase)
          sfcs_pkg::PhPayloadWait: op = sfcs_pkg::InPayload;
          sfcs_pkg::PhWeData: begin
            v[1] = (fl_cmd != sfcs_pkg::CmdWrdi) ^ (we_fails > 0);
            if (we_fails > 0) we_fails--;
          end
          sfcs_pkg::PhBusyData: begin
            v[0] = (busy_fails > 0);
            if (busy_fails > 0) busy_fails--;
          end
          default: ;
        endcase
        drive_item(make_item(op, 4'($urandom), 24'($urandom), 16'($urandom), v));
        work_items++;
      end
    end
  endtask

  task automatic run_command(logic [3:0] cmd, logic [23:0] addr, logic [15:0] cnt,
                             logic [7:0] v, int we_fails, int busy_fails);
    drive_item(make_item(sfcs_pkg::InRequest, cmd, addr, cnt, v));
    work_items++;
    drive_to_idle(we_fails, busy_fails);
  endtask

  task automatic test_ignored_at_idle();
    drive_item(make_item(sfcs_pkg::InPayload, 4'h0, 24'h000000, 16'h0000, 8'h00));
    drive_item(make_item(sfcs_pkg::InReturn, 4'hF, 24'hFFFFFF, 16'hFFFF, 8'hFF));
    drive_item(make_item(sfcs_pkg::InNone, 4'hF, 24'hFFFFFF, 16'hFFFF, 8'hFF));
    drive_item(make_item(sfcs_pkg::InRequest, 4'd9, 24'h123456, 16'h0001, 8'h01));
    drive_item(make_item(sfcs_pkg::InRequest, 4'hF, 24'hFFFFFF, 16'hFFFF, 8'hFF));
  endtask

  task automatic test_status_read();
    run_command(sfcs_pkg::CmdRdsr, 24'hFFFFFF, 16'hFFFF, 8'hFF, 0, 0);
    run_command(sfcs_pkg::CmdRdsr, 24'h000000, 16'h0000, 8'h00, 0, 0);
  endtask

  task automatic test_write_latch();
    run_command(sfcs_pkg::CmdWren, 24'h000000, 16'h0000, 8'h00, 1, 0);
    run_command(sfcs_pkg::CmdWrdi, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1, 0);
  endtask

  task automatic test_write_status();
    run_command(sfcs_pkg::CmdWrsr, 24'h000000, 16'h0000, 8'hA5, 0, 1);
  endtask

  task automatic test_program_and_read();
    run_command(sfcs_pkg::CmdProgram, 24'h000000, 16'd2, 8'h00, 0, 1);
    run_command(sfcs_pkg::CmdFastRead, 24'hABCDEF, 16'd2, 8'h00, 0, 0);
  endtask

  task automatic test_zero_length();
    run_command(sfcs_pkg::CmdProgram, 24'hFFFFFF, 16'd0, 8'h00, 0, 0);
    run_command(sfcs_pkg::CmdFastRead, 24'h800001, 16'd0, 8'h00, 0, 0);
  endtask

  task automatic test_erase_while_busy();
    noise_pct = 20;
    run_command(sfcs_pkg::CmdSectorEr, 24'h010203, 16'hFFFF, 8'h00, 0, 1);
    run_command(sfcs_pkg::CmdBlockEr, 24'hFEDCBA, 16'h0000, 8'hFF, 0, 0);
    run_command(sfcs_pkg::CmdChipErase, 24'h000000, 16'h0000, 8'h00, 0, 2);
    noise_pct = 0;
  endtask

  task automatic test_random_traffic();
    logic [3:0]  cmd;
    logic [15:0] cnt;
    int          stop_at;
    stop_at   = work_items + RandomItems;
    noise_pct = 12;
    while (work_items < stop_at) begin
      if ($urandom_range(9) == 0) begin
        drive_item(make_item(sfcs_pkg::InRequest, 4'($urandom_range(9, 15)), 24'($urandom),
                             16'($urandom), 8'($urandom)));
      end else begin
        cmd = 4'($urandom_range(8));
        cnt = (cmd == sfcs_pkg::CmdProgram || cmd == sfcs_pkg::CmdFastRead) ?
              16'($urandom_range(6)) : 16'($urandom);
        run_command(cmd, 24'($urandom), cnt, 8'($urandom), $urandom_range(2),
                    $urandom_range(3));
      end
    end
    noise_pct = 0;
  endtask

  // receiver: switches between free-running, random and heavy stall
  int rx_mode = 0;
  int rx_hold = 0;
  int rx_tick = 0;

  always @(negedge clk_i) begin
    if (rx_hold == 0) begin
      rx_mode = $urandom_range(2);
      rx_hold = $urandom_range(32, 96);
    end else begin
      rx_hold--;
    end
    rx_tick++;
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(1));
      default: out_ready_i <= (rx_tick % 8 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    sfcs_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: action %0d tx %02h data %02h last %0b",
                   out_o.action, out_o.tx_byte, out_o.data_byte, out_o.last);
      end else begin
        want = expected_results.pop_front();
        if (out_o.action !== want.action || out_o.tx_byte !== want.tx_byte ||
            out_o.data_byte !== want.data_byte || out_o.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp action %0d tx %02h data %02h last %0b,",
                     want.action, want.tx_byte, want.data_byte, want.last,
                     " got action %0d tx %02h data %02h last %0b",
                     out_o.action, out_o.tx_byte, out_o.data_byte, out_o.last);
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("spi_flash_command_sequencer verification failed");
        $finish;
      end
    end
  end

  initial begin
    fl_phase  = sfcs_pkg::PhIdle;
    fl_cmd    = 4'd0;
    fl_addr   = 24'd0;
    fl_left   = 16'd0;
    fl_idx    = 2'd0;
    fl_status = 8'd0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_ignored_at_idle();
    test_status_read();
    test_write_latch();
    test_write_status();
    test_program_and_read();
    test_zero_length();
    test_erase_while_busy();
    test_random_traffic();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("spi_flash_command_sequencer verification clean");
    end else begin
      $display("spi_flash_command_sequencer verification failed");
    end
    $finish;
  end

endmodule
